### design/cptg_pkg.sv
// Shared types and constants for the carrier pulse train generator.
// No dependencies; every other design file imports this package.
`default_nettype none

package cptg_pkg;

  localparam int PATTERN_DEPTH = 256;
  localparam int ADDR_W        = $clog2(PATTERN_DEPTH);
  localparam int TIME_W        = 48;
  localparam int POS_W         = 9;
  localparam int IDX_W         = 8;
  localparam int DUR_W         = 32;
  localparam int CFG_W         = 16;
  localparam int CFG_IDX_W     = 3;
  localparam int LEN_W         = 9;
  localparam int REP_W         = 16;
  localparam int CAR_W         = 16;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_WRITE = 2'd1,
    OP_START = 2'd2,
    OP_STOP  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_STOPPED = 2'd0,
    ST_READY   = 2'd1,
    ST_ACTIVE  = 2'd2,
    ST_PENDING = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INVERT = 3'd0,
    CFG_PERIOD = 3'd1,
    CFG_HIGH   = 3'd2,
    CFG_REPEAT = 3'd3,
    CFG_LENGTH = 3'd4
  } cfg_idx_t;

  // One classified input item as it waits for the execution stage.
  typedef struct packed {
    op_t              op;
    logic [IDX_W-1:0] idx;
    logic             idx_ok;
    logic [DUR_W-1:0] dur;
    logic [DUR_W-1:0] delay;
    logic             delay_zero;
  } cmd_t;

  typedef struct packed {
    logic             pin;
    status_t          status;
    logic [POS_W-1:0] pos;
  } res_t;

  typedef struct packed {
    logic             valid;
    cfg_idx_t         index;
    logic [CFG_W-1:0] data;
  } cfg_wr_t;

endpackage

`default_nettype wire

### design/cptg_front.sv
// Input side: accepts items, classifies them and holds them in a two-entry queue.
// Depends on cptg_pkg.
`default_nettype none

module cptg_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  logic [1:0]                  operation,
  input  logic [cptg_pkg::IDX_W-1:0]  entry_index,
  input  logic [cptg_pkg::DUR_W-1:0]  level_duration,
  input  logic [cptg_pkg::DUR_W-1:0]  start_delay,
  output cptg_pkg::cmd_t              head,
  output logic                        head_valid,
  input  logic                        head_take
);
  import cptg_pkg::*;

  cmd_t       slots [2];
  cmd_t       incoming;
  logic       wptr;
  logic       rptr;
  logic [1:0] count;
  logic       accept;

  assign full       = (count == 2'd2);
  assign accept     = push && !full;
  assign head       = slots[rptr];
  assign head_valid = (count != 2'd0);

  always_comb begin
    incoming.op         = op_t'(operation);
    incoming.idx        = entry_index;
    incoming.idx_ok     = (32'(entry_index) < PATTERN_DEPTH);
    incoming.dur        = level_duration;
    incoming.delay      = start_delay;
    incoming.delay_zero = (start_delay == '0);
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      slots[wptr] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (accept) begin
        wptr <= ~wptr;
      end
      if (head_take) begin
        rptr <= ~rptr;
      end
      case ({accept, head_take})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

### design/cptg_back.sv
// Execution side: configuration registers, pattern memory, timebase and level sequencer.
// Depends on cptg_pkg. All times are kept relative to the current tick.
`default_nettype none

module cptg_back (
  input  logic              clk,
  input  logic              rst,
  input  cptg_pkg::cfg_wr_t cfg,
  input  cptg_pkg::cmd_t    cmd,
  input  logic              cmd_valid,
  output logic              cmd_take,
  output cptg_pkg::res_t    res,
  output logic              res_valid,
  input  logic              res_room
);
  import cptg_pkg::*;

  // Configuration registers.
  logic             invert;
  logic [CAR_W-1:0] period;
  logic [CAR_W-1:0] high_time;
  logic [REP_W-1:0] rep_total;
  logic [LEN_W-1:0] plen;
  logic             hold;

  // Sequencer state; next_rel, base_rel and rise_rel are offsets from the current tick.
  logic [TIME_W-1:0] next_rel, next_rel_next;
  logic [TIME_W-1:0] base_rel, base_rel_next;
  logic [TIME_W-1:0] rise_rel, rise_rel_next;
  logic [POS_W-1:0]  position, position_next;
  logic              cln, cln_next;
  logic [REP_W-1:0]  reps, reps_next;
  logic              rep_forever, rep_forever_next;
  status_t           status, status_next;
  logic              pin, pin_next;

  // Pattern memory with one write and one registered read port.
  logic [DUR_W-1:0]  level_store [PATTERN_DEPTH];
  logic [DUR_W-1:0]  rd_data;
  logic [DUR_W-1:0]  byp_data;
  logic              byp;
  logic [DUR_W-1:0]  entry0;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;
  logic              mem_we;
  logic [DUR_W-1:0]  dur_cur;

  logic              go;
  logic              is_start;
  logic [POS_W-1:0]  len_used;
  logic [TIME_W-1:0] next_dec, base_dec, rise_dec;

  // Level event inputs and results.
  logic [TIME_W-1:0] ev_b, ev_r, ev_gap, ev_n;
  logic [POS_W-1:0]  ev_pos;
  logic              ev_cln;
  logic [REP_W-1:0]  ev_rep;
  logic              ev_forever;
  logic [DUR_W-1:0]  ev_dur;
  logic              wrap, finish, advance, bef;
  logic [POS_W-1:0]  pos_w;
  logic [REP_W-1:0]  rep_w;
  logic [CAR_W-1:0]  x_amt;
  logic [TIME_W-1:0] end_t, toggle, diff;
  logic [TIME_W-1:0] e_b, e_r, e_n;
  logic [POS_W-1:0]  e_pos;
  logic              e_cln, e_pin;
  status_t           e_status;

  // The cycle after a configuration write is skipped so that the memory read
  // reflects a new pattern length.
  assign go       = cmd_valid && res_room && !hold;
  assign cmd_take = go;
  assign is_start = (cmd.op == OP_START);
  assign len_used = (32'(plen) > PATTERN_DEPTH) ? POS_W'(PATTERN_DEPTH) : plen;
  assign next_dec = next_rel - TIME_W'(1);
  assign base_dec = base_rel - TIME_W'(1);
  assign rise_dec = rise_rel - TIME_W'(1);
  assign dur_cur  = byp ? byp_data : rd_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      invert    <= 1'b0;
      period    <= '0;
      high_time <= '0;
      rep_total <= REP_W'(1);
      plen      <= LEN_W'(1);
      hold      <= 1'b0;
    end else begin
      hold <= cfg.valid;
      if (cfg.valid) begin
        case (cfg.index)
          CFG_INVERT: invert    <= cfg.data[0];
          CFG_PERIOD: period    <= cfg.data[CAR_W-1:0];
          CFG_HIGH:   high_time <= cfg.data[CAR_W-1:0];
          CFG_REPEAT: rep_total <= cfg.data[REP_W-1:0];
          CFG_LENGTH: plen      <= cfg.data[LEN_W-1:0];
          default:    ;
        endcase
      end
    end
  end

  // Operands of a level event: a start with no delay runs from offset zero.
  always_comb begin
    ev_b       = is_start ? '0 : base_dec;
    ev_r       = is_start ? '0 : rise_dec;
    ev_n       = is_start ? '0 : next_dec;
    ev_gap     = is_start ? '0 : (base_rel - rise_rel);
    ev_pos     = is_start ? '0 : position;
    ev_cln     = is_start ? 1'b0 : cln;
    ev_rep     = is_start ? rep_total : reps;
    ev_forever = is_start ? (rep_total == '0) : rep_forever;
    ev_dur     = is_start ? entry0 : dur_cur;
  end

  always_comb begin
    wrap   = (ev_pos >= len_used);
    pos_w  = wrap ? '0 : ev_pos;
    rep_w  = wrap ? (ev_rep - REP_W'(1)) : ev_rep;
    finish = wrap && (rep_w == '0) && !ev_forever;
    end_t  = ev_b + TIME_W'(ev_dur);
    x_amt  = ev_cln ? period : high_time;
    toggle = ev_r + TIME_W'(x_amt);
    // End of level minus the carrier toggle time.
    diff   = ev_gap + TIME_W'(ev_dur) - TIME_W'(x_amt);
    bef    = (diff != '0) && !diff[TIME_W-1];

    e_b      = ev_b;
    e_r      = ev_r;
    e_n      = ev_n;
    e_pos    = pos_w;
    e_cln    = ev_cln;
    e_pin    = 1'b0;
    e_status = ST_ACTIVE;
    advance  = 1'b0;
    if (finish) begin
      e_status = ST_READY;
    end else if (pos_w[0]) begin
      e_r     = end_t;
      e_cln   = 1'b0;
      advance = 1'b1;
    end else begin
      e_pin = 1'b1;
      if (high_time == '0) begin
        advance = 1'b1;
      end else begin
        if (ev_cln) begin
          e_pin = 1'b0;
          e_r   = toggle;
          e_cln = 1'b0;
        end else begin
          e_cln = 1'b1;
        end
        if (bef) begin
          e_n = toggle;
        end else begin
          advance = 1'b1;
        end
      end
    end
    if (advance) begin
      e_b   = end_t;
      e_n   = end_t;
      e_pos = pos_w + POS_W'(1);
    end
  end

  always_comb begin
    next_rel_next    = next_rel;
    base_rel_next    = base_rel;
    rise_rel_next    = rise_rel;
    position_next    = position;
    cln_next         = cln;
    reps_next        = reps;
    rep_forever_next = rep_forever;
    status_next      = status;
    pin_next         = pin;
    if (go) begin
      case (cmd.op)
        OP_TICK: begin
          next_rel_next = next_dec;
          base_rel_next = base_dec;
          rise_rel_next = rise_dec;
          if ((status == ST_ACTIVE || status == ST_PENDING) &&
              (next_dec == '0 || next_dec[TIME_W-1])) begin
            next_rel_next = e_n;
            base_rel_next = e_b;
            rise_rel_next = e_r;
            position_next = e_pos;
            cln_next      = e_cln;
            reps_next     = rep_w;
            status_next   = e_status;
            pin_next      = e_pin;
          end
        end
        OP_START: begin
          if (plen != '0) begin
            rep_forever_next = (rep_total == '0);
            if (cmd.delay_zero) begin
              next_rel_next = e_n;
              base_rel_next = e_b;
              rise_rel_next = e_r;
              position_next = e_pos;
              cln_next      = e_cln;
              reps_next     = rep_w;
              status_next   = e_status;
              pin_next      = e_pin;
            end else begin
              next_rel_next = TIME_W'(cmd.delay);
              base_rel_next = TIME_W'(cmd.delay);
              rise_rel_next = TIME_W'(cmd.delay);
              position_next = '0;
              cln_next      = 1'b0;
              reps_next     = rep_total;
              status_next   = ST_PENDING;
            end
          end
        end
        OP_STOP: begin
          status_next = ST_STOPPED;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      next_rel    <= '0;
      base_rel    <= '0;
      rise_rel    <= '0;
      position    <= '0;
      cln         <= 1'b0;
      reps        <= '0;
      rep_forever <= 1'b0;
      status      <= ST_STOPPED;
      pin         <= 1'b0;
    end else begin
      next_rel    <= next_rel_next;
      base_rel    <= base_rel_next;
      rise_rel    <= rise_rel_next;
      position    <= position_next;
      cln         <= cln_next;
      reps        <= reps_next;
      rep_forever <= rep_forever_next;
      status      <= status_next;
      pin         <= pin_next;
    end
  end

  // The read port always fetches the entry the next event will use, so the
  // duration is ready for an item in the following cycle.
  assign rd_addr = (position_next >= len_used) ? '0 : ADDR_W'(position_next);
  assign wr_addr = ADDR_W'(cmd.idx);
  assign mem_we  = go && (cmd.op == OP_WRITE) && cmd.idx_ok;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      level_store[wr_addr] <= cmd.dur;
    end
    rd_data  <= level_store[rd_addr];
    byp      <= mem_we && (wr_addr == rd_addr);
    byp_data <= cmd.dur;
    if (mem_we && (wr_addr == '0)) begin
      entry0 <= cmd.dur;
    end
  end

  always_comb begin
    res.pin    = pin_next ^ invert;
    res.status = status_next;
    res.pos    = position_next;
  end
  assign res_valid = go;

`ifndef SYNTH
  a_ready_at_start: assert property (@(posedge clk) disable iff (rst)
    (status == ST_READY) |-> (position == '0))
    else $error("finished sequencer left a nonzero position");

  a_stop: assert property (@(posedge clk) disable iff (rst)
    (go && cmd.op == OP_STOP) |=> (status == ST_STOPPED))
    else $error("stop item did not stop the sequencer");

  a_delayed_start: assert property (@(posedge clk) disable iff (rst)
    (go && cmd.op == OP_START && plen != '0 && !cmd.delay_zero) |=>
      (status == ST_PENDING && position == '0 &&
       next_rel == TIME_W'($past(cmd.delay))))
    else $error("delayed start did not arm the first event");

  a_idle_holds: assert property (@(posedge clk) disable iff (rst)
    !go |=> (position == $past(position) && status == $past(status) &&
             next_rel == $past(next_rel)))
    else $error("sequencer state moved without an item");
`endif

endmodule

`default_nettype wire

### design/cptg_out.sv
// Result side: a two-entry queue of result items read by empty and pop.
// Depends on cptg_pkg.
`default_nettype none

module cptg_out (
  input  logic                       clk,
  input  logic                       rst,
  input  cptg_pkg::res_t             res,
  input  logic                       res_valid,
  output logic                       res_room,
  output logic                       empty,
  input  logic                       pop,
  output logic                       pin_level,
  output logic [1:0]                 run_status,
  output logic [cptg_pkg::POS_W-1:0] pattern_position
);
  import cptg_pkg::*;

  res_t       slots [2];
  res_t       head;
  logic       wptr;
  logic       rptr;
  logic [1:0] count;
  logic       take;

  assign res_room         = (count != 2'd2);
  assign empty            = (count == 2'd0);
  assign take             = pop && !empty;
  assign head             = slots[rptr];
  assign pin_level        = head.pin;
  assign run_status       = head.status;
  assign pattern_position = head.pos;

  always_ff @(posedge clk) begin
    if (res_valid) begin
      slots[wptr] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (res_valid) begin
        wptr <= ~wptr;
      end
      if (take) begin
        rptr <= ~rptr;
      end
      case ({res_valid, take})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

### design/carrier_pulse_train_generator_top.sv
// Carrier pulse train generator: one item per clock cycle sustained while results are
// popped; each result is registered in the output queue that drives the result ports.
// The execution stage pauses in the cycle after each configuration write.
// Reset (rst, synchronous, active high) clears queues, registers and the sequencer;
// the pattern memory is not cleared and must be written before it is used.
// Depends on cptg_pkg, cptg_front, cptg_back and cptg_out.
`default_nettype none

module carrier_pulse_train_generator_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  output logic                           full,
  input  logic [1:0]                     operation,
  input  logic [cptg_pkg::IDX_W-1:0]     entry_index,
  input  logic [cptg_pkg::DUR_W-1:0]     level_duration,
  input  logic [cptg_pkg::DUR_W-1:0]     start_delay,
  output logic                           empty,
  input  logic                           pop,
  output logic                           pin_level,
  output logic [1:0]                     run_status,
  output logic [cptg_pkg::POS_W-1:0]     pattern_position,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [cptg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cptg_pkg::CFG_W-1:0]     cfg_data
);
  import cptg_pkg::*;

  cmd_t    head;
  logic    head_valid;
  logic    head_take;
  res_t    res;
  logic    res_valid;
  logic    res_room;
  cfg_wr_t cfg;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg.valid = cfg_valid;
    cfg.index = cfg_idx_t'(cfg_index);
    cfg.data  = cfg_data;
  end

  cptg_front u_front (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .operation      (operation),
    .entry_index    (entry_index),
    .level_duration (level_duration),
    .start_delay    (start_delay),
    .head           (head),
    .head_valid     (head_valid),
    .head_take      (head_take)
  );

  cptg_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd       (head),
    .cmd_valid (head_valid),
    .cmd_take  (head_take),
    .res       (res),
    .res_valid (res_valid),
    .res_room  (res_room)
  );

  cptg_out u_out (
    .clk              (clk),
    .rst              (rst),
    .res              (res),
    .res_valid        (res_valid),
    .res_room         (res_room),
    .empty            (empty),
    .pop              (pop),
    .pin_level        (pin_level),
    .run_status       (run_status),
    .pattern_position (pattern_position)
  );

endmodule

`default_nettype wire
